FILE: design/lrfc_pkg.sv
// lrfc_pkg: types, constants and the crc32c byte function of the log record
// frame checker. No dependencies; the frame checker module imports it.
package lrfc_pkg;

  // byte counter and configuration widths
  localparam int unsigned CountW   = 13;
  localparam int unsigned CfgW     = 13;
  localparam int unsigned CfgAddrW = 4;
  localparam int unsigned ApbDataW = 32;

  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  // record layout
  localparam logic [CountW-1:0] LenEnd     = CountW'(4);
  localparam logic [CountW-1:0] VersionEnd = CountW'(6);
  localparam logic [CountW-1:0] KindPos    = CountW'(6);
  localparam logic [CountW-1:0] FlagsPos   = CountW'(7);
  localparam logic [CountW-1:0] PrefixEnd  = CountW'(16);
  localparam logic [CountW-1:0] TailBytes  = CountW'(4);

  // record rules
  localparam logic [15:0] RecordVersion  = 16'd1;
  localparam logic [7:0]  KindSubmit     = 8'd1;
  localparam logic [7:0]  KindCancel     = 8'd2;
  localparam logic [31:0] MaxRecordBytes = 32'd4096;

  // register reset values
  localparam logic [CfgW-1:0] CancelSizeRst = CfgW'(44);
  localparam logic [CfgW-1:0] SubmitSizeRst = CfgW'(69);
  localparam logic [CfgW-1:0] MaxSizeRst    = CfgW'(69);

  // crc32c, reflected form
  localparam logic [31:0] CrcPoly = 32'h82F6_3B78;
  localparam logic [31:0] CrcInit = 32'hFFFF_FFFF;

  typedef enum logic [3:0] {
    VerdictOk,
    VerdictBadLength,
    VerdictExcessive,
    VerdictCrc,
    VerdictVersion,
    VerdictType,
    VerdictFlags,
    VerdictSize,
    VerdictZeroSeq,
    VerdictSeqMismatch
  } verdict_e;

  typedef enum logic [1:0] {
    RecUnknown,
    RecSubmit,
    RecCancel
  } record_kind_e;

  typedef enum logic [1:0] {
    CfgCancelSize,
    CfgSubmitSize,
    CfgMaxSize
  } cfg_reg_e;

  // one byte through the reflected crc32c register
  function automatic logic [31:0] crc32c_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (CrcPoly & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

FILE: design/lrfc_in_if.sv
// lrfc_in_if: byte channel into the log record frame checker.
// Carries one record byte per word with its last-byte and new-log marks.
interface lrfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;
  logic       new_log;

  modport source (output valid, output data_byte, output final_byte, output new_log,
                  input ready);
  modport sink (input valid, input data_byte, input final_byte, input new_log,
                output ready);
endinterface

FILE: design/lrfc_out_if.sv
// lrfc_out_if: verdict channel out of the log record frame checker.
// One word per record: verdict, kind, sequence and declared length.
interface lrfc_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  verdict;
  logic [1:0]  record_kind;
  logic [63:0] record_sequence;
  logic [31:0] declared_length;

  modport source (output valid, output verdict, output record_kind,
                  output record_sequence, output declared_length, input ready);
  modport sink (input valid, input verdict, input record_kind,
                input record_sequence, input declared_length, output ready);
endinterface

FILE: design/log_record_frame_checker.sv
// log_record_frame_checker: framing, crc32c and sequence check of log records.
// Depends on lrfc_pkg, lrfc_in_if and lrfc_out_if.
//
// Usage: rec_i carries a record one byte per word, with final_byte on the
// last byte and new_log on the first byte of the first record of a log.
// res_o gives one word per record: the verdict (first failing check wins),
// the record kind, the sequence and the length read from the prefix.
// A byte is taken into an input register; from there the per-record state
// (prefix fields, crc, four-byte tail, byte count) is updated and, on the
// last byte, the verdict lands in the result register. Throughput is one
// byte per cycle while no last byte waits on a stalled result, set by the
// one-byte crc32c update between the registers. A stalled result blocks only
// the next last byte; other bytes keep flowing.
// Reset clears the record state, sets the expected sequence to 1 and loads
// the size registers with their defaults. The user writes sizes over the APB
// port only while no record is in flight (not enforced); reads return the stored value.
module log_record_frame_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  lrfc_in_if.sink                      rec_i,
  lrfc_out_if.source                   res_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lrfc_pkg::CfgAddrW-1:0] paddr,
  input  logic [lrfc_pkg::ApbDataW-1:0] pwdata,
  output logic [lrfc_pkg::ApbDataW-1:0] prdata,
  output logic                         pready
);
  import lrfc_pkg::*;

  // configuration registers
  logic [CfgW-1:0] cancel_size_q, submit_size_q, max_size_q;
  logic            cfg_we;
  cfg_reg_e        cfg_sel;

  // input register
  logic            item_valid_q;
  logic [7:0]      item_byte_q;
  logic            item_last_q;
  logic            item_fresh_q;
  logic            proc;

  // per-record state
  logic [31:0]       crc_q, crc_d;
  logic [CountW-1:0] count_q, count_d;
  logic [31:0]       length_q, length_d;
  logic [15:0]       version_q, version_d;
  logic [7:0]        kind_q, kind_d;
  logic [7:0]        flags_q, flags_d;
  logic [63:0]       seq_q, seq_d;
  logic [31:0]       tail_q, tail_d;
  logic [63:0]       expected_q, expected_d;
  logic [63:0]       expected_eff;

  // judgment
  verdict_e          verdict;
  record_kind_e      kind_code;
  logic [CfgW-1:0]   want_size;
  logic              kind_known;

  // result register
  logic              out_valid_q;
  verdict_e          out_verdict_q;
  record_kind_e      out_kind_q;
  logic [63:0]       out_seq_q;
  logic [31:0]       out_len_q;

  // apb register file
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign cfg_sel = cfg_reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cancel_size_q <= CancelSizeRst;
      submit_size_q <= SubmitSizeRst;
      max_size_q    <= MaxSizeRst;
    end else if (cfg_we) begin
      case (cfg_sel)
        CfgCancelSize: cancel_size_q <= pwdata[CfgW-1:0];
        CfgSubmitSize: submit_size_q <= pwdata[CfgW-1:0];
        CfgMaxSize:    max_size_q    <= pwdata[CfgW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      CfgCancelSize: prdata = ApbDataW'(cancel_size_q);
      CfgSubmitSize: prdata = ApbDataW'(submit_size_q);
      CfgMaxSize:    prdata = ApbDataW'(max_size_q);
      default:       prdata = '0;
    endcase
  end

  // handshake: a last byte waits only while the result register is full and not taken
  assign proc        = item_valid_q && (!item_last_q || !out_valid_q || res_o.ready);
  assign rec_i.ready = !item_valid_q || proc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (rec_i.ready) begin
      item_valid_q <= rec_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rec_i.ready && rec_i.valid) begin
      item_byte_q  <= rec_i.data_byte;
      item_last_q  <= rec_i.final_byte;
      item_fresh_q <= rec_i.new_log;
    end
  end

  // state update for the byte in the input register
  always_comb begin
    length_d  = length_q;
    version_d = version_q;
    kind_d    = kind_q;
    flags_d   = flags_q;
    seq_d     = seq_q;
    if (count_q < LenEnd) begin
      length_d[8*count_q[1:0] +: 8] = item_byte_q;
    end else if (count_q < VersionEnd) begin
      version_d[8*count_q[0] +: 8] = item_byte_q;
    end else if (count_q == KindPos) begin
      kind_d = item_byte_q;
    end else if (count_q == FlagsPos) begin
      flags_d = item_byte_q;
    end else if (count_q < PrefixEnd) begin
      seq_d[8*count_q[2:0] +: 8] = item_byte_q;
    end
    crc_d   = (count_q >= TailBytes) ? crc32c_byte(crc_q, tail_q[7:0]) : crc_q;
    tail_d  = {item_byte_q, tail_q[31:8]};
    count_d = (count_q == CountMax) ? count_q : count_q + CountW'(1);
    expected_eff = (count_q == '0 && item_fresh_q) ? 64'd1 : expected_q;
  end

  // verdict from the updated state
  assign kind_known = (kind_d == KindSubmit) || (kind_d == KindCancel);
  assign want_size  = (kind_d == KindSubmit) ? submit_size_q : cancel_size_q;

  always_comb begin
    if (count_d < TailBytes) begin
      verdict = VerdictBadLength;
    end else if (length_d < 32'(cancel_size_q)) begin
      verdict = VerdictBadLength;
    end else if (length_d > 32'(max_size_q) || length_d > MaxRecordBytes) begin
      verdict = VerdictExcessive;
    end else if (count_d == CountMax || length_d != 32'(count_d)) begin
      verdict = VerdictBadLength;
    end else if (~crc_d != tail_d) begin
      verdict = VerdictCrc;
    end else if (version_d != RecordVersion) begin
      verdict = VerdictVersion;
    end else if (!kind_known) begin
      verdict = VerdictType;
    end else if (flags_d != 8'd0) begin
      verdict = VerdictFlags;
    end else if (count_d != want_size) begin
      verdict = VerdictSize;
    end else if (seq_d == 64'd0) begin
      verdict = VerdictZeroSeq;
    end else if (seq_d != expected_eff) begin
      verdict = VerdictSeqMismatch;
    end else begin
      verdict = VerdictOk;
    end
  end

  always_comb begin
    if (kind_d == KindSubmit) begin
      kind_code = RecSubmit;
    end else if (kind_d == KindCancel) begin
      kind_code = RecCancel;
    end else begin
      kind_code = RecUnknown;
    end
  end

  // expected sequence advances on every accepted record
  assign expected_d = (item_last_q && verdict == VerdictOk) ? expected_eff + 64'd1
                                                            : expected_eff;

  // record state registers, cleared after the last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q      <= CrcInit;
      count_q    <= '0;
      length_q   <= '0;
      version_q  <= '0;
      kind_q     <= '0;
      flags_q    <= '0;
      seq_q      <= '0;
      tail_q     <= '0;
      expected_q <= 64'd1;
    end else if (proc) begin
      expected_q <= expected_d;
      if (item_last_q) begin
        crc_q     <= CrcInit;
        count_q   <= '0;
        length_q  <= '0;
        version_q <= '0;
        kind_q    <= '0;
        flags_q   <= '0;
        seq_q     <= '0;
        tail_q    <= '0;
      end else begin
        crc_q     <= crc_d;
        count_q   <= count_d;
        length_q  <= length_d;
        version_q <= version_d;
        kind_q    <= kind_d;
        flags_q   <= flags_d;
        seq_q     <= seq_d;
        tail_q    <= tail_d;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc && item_last_q) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && item_last_q) begin
      out_verdict_q <= verdict;
      out_kind_q    <= kind_code;
      out_seq_q     <= seq_d;
      out_len_q     <= length_d;
    end
  end

  assign res_o.valid           = out_valid_q;
  assign res_o.verdict         = out_verdict_q;
  assign res_o.record_kind     = out_kind_q;
  assign res_o.record_sequence = out_seq_q;
  assign res_o.declared_length = out_len_q;

  // crc register holds its seed until the first byte past the tail window
  a_crc_seed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= TailBytes |-> crc_q == CrcInit)
    else $error("crc register left its seed too early");

  // a passing record always names a known kind
  a_ok_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_verdict_q == VerdictOk |-> out_kind_q != RecUnknown)
    else $error("passing record with unknown kind");

  // a passing record has one of the configured sizes
  a_ok_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_verdict_q == VerdictOk |->
      (out_len_q == 32'(cancel_size_q) || out_len_q == 32'(submit_size_q)))
    else $error("passing record with unexpected length");

  // a last byte never overwrites a result that is still waiting
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !res_o.ready && item_valid_q && item_last_q |-> !proc)
    else $error("pending result overwritten");

  // a record restarts with a clear counter after its last byte
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && item_last_q |=> count_q == '0 && tail_q == '0)
    else $error("record state not cleared after last byte");

endmodule
